// ----- hw/rtl/rrd_pkg.sv -----
// Shared types and codes for the RGB565 run-length rectangle decoder.
// Holds item mode codes, result status codes, the decoder state record
// and the divisibility-by-three helper. No dependencies.
package rrd_pkg;

    localparam int PIX_W   = 17;
    localparam int BYTES_W = 18;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_END   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_RUN        = 4'd0,
        ST_RECT_OK    = 4'd1,
        ST_RECT_DONE  = 4'd2,
        ST_BAD_HEADER = 4'd3,
        ST_ZERO_RUN   = 4'd4,
        ST_EXHAUSTED  = 4'd5,
        ST_OVERRUN    = 4'd6,
        ST_INCOMPLETE = 4'd7,
        ST_IDLE       = 4'd8
    } status_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixels_expected;
        logic [PIX_W-1:0]   pixels_decoded;
        logic [BYTES_W-1:0] bytes_remaining;
        logic               rect_active;
        logic               error_seen;
    } dec_state_t;

    typedef struct packed {
        status_t          status;
        logic [15:0]      pixel;
        logic [7:0]       count;
        logic [PIX_W-1:0] index;
    } dec_result_t;

    // 4 == 1 mod 3, so summing base-4 digits keeps the residue
    function automatic logic div3(input logic [BYTES_W-1:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = '0;
        for (int i = 0; i < BYTES_W / 2; i++)
        begin
            s1 = s1 + {3'b000, v[2*i +: 2]};
        end
        s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]} + {2'b00, s1[4]};
        s3 = {1'b0, s2[1:0]} + {2'b00, s2[2]};
        return (s3 == 3'd0) || (s3 == 3'd3);
    endfunction

endpackage

// ----- hw/rtl/rrd_step.sv -----
// Next-state and result logic for one decoder item.
// Depends on rrd_pkg for the state record, result record and codes.
module rrd_step #(
    parameter int MAX_WIDTH  = 240,
    parameter int MAX_HEIGHT = 320
) (
    input  rrd_pkg::dec_state_t  cur,
    input  logic [1:0]           mode,
    input  logic [7:0]           rect_width,
    input  logic [8:0]           rect_height,
    input  logic [17:0]          payload_bytes,
    input  logic [7:0]           run_count,
    input  logic [15:0]          pixel_value,
    output rrd_pkg::dec_state_t  nxt,
    output rrd_pkg::dec_result_t res
);
    import rrd_pkg::*;

    localparam int HBITS = $clog2(MAX_HEIGHT + 1);
    localparam int HCW   = (HBITS > 9) ? HBITS : 9;

    logic             bad_header;
    logic [PIX_W:0]   run_end;
    logic [PIX_W-1:0] area;
    logic             open_rect;

    assign bad_header = (payload_bytes == '0) || !div3(payload_bytes)
                        || (rect_width > 8'(MAX_WIDTH))
                        || (HCW'(rect_height) > HCW'(MAX_HEIGHT));
    assign area       = PIX_W'(rect_width * rect_height);
    assign run_end    = {1'b0, cur.pixels_decoded} + (PIX_W + 1)'(run_count);
    assign open_rect  = cur.rect_active && !cur.error_seen;

    always_comb
    begin
        nxt = cur;
        res = '{status: ST_IDLE, pixel: '0, count: '0, index: '0};
        case (mode_t'(mode))
            MODE_START:
            begin
                nxt.error_seen     = 1'b0;
                nxt.pixels_decoded = '0;
                if (bad_header)
                begin
                    nxt.pixels_expected = '0;
                    nxt.bytes_remaining = '0;
                    nxt.error_seen      = 1'b1;
                    nxt.rect_active     = 1'b0;
                    res.status          = ST_BAD_HEADER;
                end
                else
                begin
                    nxt.pixels_expected = area;
                    nxt.bytes_remaining = payload_bytes;
                    nxt.rect_active     = 1'b1;
                    res.status          = ST_RECT_OK;
                end
            end
            MODE_RUN:
            begin
                if (open_rect)
                begin
                    if (cur.bytes_remaining < BYTES_W'(3))
                    begin
                        nxt.error_seen  = 1'b1;
                        nxt.rect_active = 1'b0;
                        res.status      = ST_EXHAUSTED;
                    end
                    else if (run_count == '0)
                    begin
                        nxt.error_seen  = 1'b1;
                        nxt.rect_active = 1'b0;
                        res.status      = ST_ZERO_RUN;
                    end
                    else if (run_end > {1'b0, cur.pixels_expected})
                    begin
                        nxt.error_seen  = 1'b1;
                        nxt.rect_active = 1'b0;
                        res.status      = ST_OVERRUN;
                    end
                    else
                    begin
                        res.status          = ST_RUN;
                        res.pixel           = pixel_value;
                        res.count           = run_count;
                        res.index           = cur.pixels_decoded;
                        nxt.pixels_decoded  = run_end[PIX_W-1:0];
                        nxt.bytes_remaining = cur.bytes_remaining - BYTES_W'(3);
                    end
                end
            end
            MODE_END:
            begin
                if (open_rect)
                begin
                    nxt.rect_active = 1'b0;
                    if ((cur.bytes_remaining == '0)
                        && (cur.pixels_decoded == cur.pixels_expected))
                    begin
                        res.status = ST_RECT_DONE;
                    end
                    else
                    begin
                        nxt.error_seen = 1'b1;
                        res.status     = ST_INCOMPLETE;
                    end
                end
            end
            default:
            begin
                res.status = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/rgb565_rle_rect_decoder_core.sv -----
// Top level of the RGB565 run-length rectangle decoder.
// Depends on rrd_pkg and rrd_step.
//
// Usage: the input channel (in_valid/in_ready) carries one item per
// handshake: a rect start (width, height, payload length), a run triple
// (count, pixel) or a rect end. Each accepted item yields exactly one
// result item on the output channel (out_valid/out_ready): a status code
// and, for an emitted run, its pixel, count and linear start index.
// The result is registered at the edge that accepts the item. Throughput
// is one item per cycle while the receiver takes results; the single
// output register is refilled in the same cycle that it is taken.
// If the receiver stalls, the held result stays on the outputs and
// in_ready drops until it is taken; no item is lost.
// Reset clears the rectangle state (no rectangle open, no error, all
// counters zero) and empties the output register. Errors stick until
// the next rect start.
module rgb565_rle_rect_decoder_core #(
    parameter int MAX_WIDTH  = 240,
    parameter int MAX_HEIGHT = 320
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  rect_width,
    input  logic [8:0]  rect_height,
    input  logic [17:0] payload_bytes,
    input  logic [7:0]  run_count,
    input  logic [15:0] pixel_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [15:0] out_pixel,
    output logic [7:0]  out_count,
    output logic [16:0] start_index
);
    import rrd_pkg::*;

    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t result_reg;
    dec_result_t result_next;
    logic        out_valid_reg;
    logic        in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    rrd_step #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_step (
        .cur           (state_reg),
        .mode          (mode),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .payload_bytes (payload_bytes),
        .run_count     (run_count),
        .pixel_value   (pixel_value),
        .nxt           (state_next),
        .res           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign out_pixel   = result_reg.pixel;
    assign out_count   = result_reg.count;
    assign start_index = result_reg.index;

    a_active_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.rect_active |-> !state_reg.error_seen)
        else $error("open rectangle carries an error");

    a_decoded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pixels_decoded <= state_reg.pixels_expected)
        else $error("decoded pixels exceed rectangle total");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.status == ST_RUN)) |-> (result_reg.count != '0))
        else $error("emitted run has zero count");

    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (mode == MODE_NONE)) |=> ($stable(state_reg)
            && (result_reg.status == ST_IDLE)))
        else $error("unused mode changed state");

endmodule
